// ----- rtl/core/pei_pkg.sv -----
// Shared widths, curve codes and sideband type for the polynomial easing interpolator.
// No dependencies; every other file in rtl/core uses this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package pei_pkg;

    localparam int VALUE_BITS = 16;
    localparam int FUNC_W     = 3;
    localparam int STEP_W     = 8;
    localparam int OUT_W      = 32;

    localparam int DIFF_W     = VALUE_BITS + 1;
    localparam int BASE_W     = STEP_W + 1;
    localparam int P2_W       = 2 * BASE_W;
    localparam int P3_W       = 3 * BASE_W;
    localparam int P4_W       = 4 * BASE_W;
    localparam int T2_W       = 2 * STEP_W;
    localparam int T3_W       = 3 * STEP_W;
    localparam int POW_W      = 4 * STEP_W;
    localparam int NUM_W      = DIFF_W + POW_W;
    localparam int SUM_W      = NUM_W + 2;

    localparam logic [FUNC_W-1:0] FN_LINEAR    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_QUAD_IN   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CUBIC_IN  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_QUART_IN  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUAD_OUT  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CUBIC_OUT = 3'd5;

    localparam logic [1:0] KIND_POLY = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]                   kind;
        logic                         neg;
        logic                         sub;
        logic signed [VALUE_BITS-1:0] offset;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/core/pei_power.sv -----
// Front pipeline: curve decode, step powers, magnitude of the scaled difference.
// Depends on pei_pkg. Six register stages, all advancing on i_en.
`timescale 1ns / 1ps
`default_nettype none

module pei_power (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_en,
    input  wire                                      i_valid,
    input  wire [pei_pkg::FUNC_W-1:0]                i_func,
    input  wire signed [pei_pkg::VALUE_BITS-1:0]     i_start_value,
    input  wire signed [pei_pkg::VALUE_BITS-1:0]     i_end_value,
    input  wire [pei_pkg::STEP_W-1:0]                i_step_now,
    input  wire [pei_pkg::STEP_W-1:0]                i_step_total,
    output logic                                     o_valid,
    output logic [pei_pkg::NUM_W-1:0]                o_num,
    output logic [pei_pkg::POW_W-1:0]                o_den,
    output pei_pkg::t_side                           o_side
);

    logic [5:0] r_v;

    // stage 1
    logic signed [pei_pkg::BASE_W-1:0] r1_p1, n1_p1;
    logic [pei_pkg::STEP_W-1:0]        r1_t1;
    logic [1:0]                        r1_ksel, n1_ksel;
    logic signed [pei_pkg::DIFF_W-1:0] r1_diff;
    pei_pkg::t_side                    r1_side, n1_side;
    // stage 2
    logic signed [pei_pkg::BASE_W-1:0] r2_p1;
    logic signed [pei_pkg::P2_W-1:0]   r2_p2;
    logic [pei_pkg::STEP_W-1:0]        r2_t1;
    logic [pei_pkg::T2_W-1:0]          r2_t2;
    logic [1:0]                        r2_ksel;
    logic signed [pei_pkg::DIFF_W-1:0] r2_diff;
    pei_pkg::t_side                    r2_side;
    // stage 3
    logic signed [pei_pkg::BASE_W-1:0] r3_p1;
    logic signed [pei_pkg::P2_W-1:0]   r3_p2;
    logic signed [pei_pkg::P3_W-1:0]   r3_p3;
    logic [pei_pkg::STEP_W-1:0]        r3_t1;
    logic [pei_pkg::T2_W-1:0]          r3_t2;
    logic [pei_pkg::T3_W-1:0]          r3_t3;
    logic [1:0]                        r3_ksel;
    logic signed [pei_pkg::DIFF_W-1:0] r3_diff;
    pei_pkg::t_side                    r3_side;
    // stage 4
    logic signed [pei_pkg::BASE_W-1:0] r4_p1;
    logic signed [pei_pkg::P2_W-1:0]   r4_p2;
    logic signed [pei_pkg::P3_W-1:0]   r4_p3;
    logic signed [pei_pkg::P4_W-1:0]   r4_p4;
    logic [pei_pkg::STEP_W-1:0]        r4_t1;
    logic [pei_pkg::T2_W-1:0]          r4_t2;
    logic [pei_pkg::T3_W-1:0]          r4_t3;
    logic [pei_pkg::POW_W-1:0]         r4_t4;
    logic [1:0]                        r4_ksel;
    logic signed [pei_pkg::DIFF_W-1:0] r4_diff;
    pei_pkg::t_side                    r4_side;
    // stage 5
    logic [pei_pkg::POW_W-1:0]         r5_pmag;
    logic [pei_pkg::POW_W-1:0]         r5_den;
    logic [pei_pkg::DIFF_W-1:0]        r5_dmag;
    pei_pkg::t_side                    r5_side;
    // stage 6
    logic [pei_pkg::NUM_W-1:0]         r6_num;
    logic [pei_pkg::POW_W-1:0]         r6_den;
    pei_pkg::t_side                    r6_side;

    logic signed [pei_pkg::P4_W-1:0]   n5_pk;
    logic [pei_pkg::POW_W-1:0]         n5_tk;
    logic [pei_pkg::P4_W-1:0]          n5_pabs;
    logic signed [pei_pkg::DIFF_W-1:0] n5_dabs;
    pei_pkg::t_side                    n5_side;
    logic                              is_out;

    always_comb begin
        is_out = (i_func == pei_pkg::FN_QUAD_OUT) || (i_func == pei_pkg::FN_CUBIC_OUT);
        if (is_out) begin
            n1_p1   = $signed({1'b0, i_step_total}) - $signed({1'b0, i_step_now});
            n1_ksel = i_func[1:0] - 2'd3;
        end else begin
            n1_p1   = $signed({1'b0, i_step_now});
            n1_ksel = i_func[1:0];
        end
        n1_side.sub    = is_out;
        n1_side.neg    = 1'b0;
        n1_side.offset = is_out ? i_end_value : i_start_value;
        if (i_step_total == '0) begin
            n1_side.kind   = pei_pkg::KIND_END;
            n1_side.offset = i_end_value;
        end else if (i_func > pei_pkg::FN_CUBIC_OUT) begin
            n1_side.kind = pei_pkg::KIND_ZERO;
        end else begin
            n1_side.kind = pei_pkg::KIND_POLY;
        end
    end

    always_comb begin
        case (r4_ksel)
            2'd0: begin
                n5_pk = {{(pei_pkg::P4_W-pei_pkg::BASE_W){r4_p1[pei_pkg::BASE_W-1]}}, r4_p1};
                n5_tk = {{(pei_pkg::POW_W-pei_pkg::STEP_W){1'b0}}, r4_t1};
            end
            2'd1: begin
                n5_pk = {{(pei_pkg::P4_W-pei_pkg::P2_W){r4_p2[pei_pkg::P2_W-1]}}, r4_p2};
                n5_tk = {{(pei_pkg::POW_W-pei_pkg::T2_W){1'b0}}, r4_t2};
            end
            2'd2: begin
                n5_pk = {{(pei_pkg::P4_W-pei_pkg::P3_W){r4_p3[pei_pkg::P3_W-1]}}, r4_p3};
                n5_tk = {{(pei_pkg::POW_W-pei_pkg::T3_W){1'b0}}, r4_t3};
            end
            default: begin
                n5_pk = r4_p4;
                n5_tk = r4_t4;
            end
        endcase
        n5_pabs = n5_pk[pei_pkg::P4_W-1] ? $unsigned(-n5_pk) : $unsigned(n5_pk);
        n5_dabs = r4_diff[pei_pkg::DIFF_W-1] ? -r4_diff : r4_diff;
        n5_side     = r4_side;
        n5_side.neg = r4_diff[pei_pkg::DIFF_W-1] ^ n5_pk[pei_pkg::P4_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p1   <= n1_p1;
            r1_t1   <= i_step_total;
            r1_ksel <= n1_ksel;
            r1_diff <= $signed({i_end_value[pei_pkg::VALUE_BITS-1], i_end_value})
                     - $signed({i_start_value[pei_pkg::VALUE_BITS-1], i_start_value});
            r1_side <= n1_side;

            r2_p1   <= r1_p1;
            r2_p2   <= pei_pkg::P2_W'(r1_p1) * pei_pkg::P2_W'(r1_p1);
            r2_t1   <= r1_t1;
            r2_t2   <= pei_pkg::T2_W'(r1_t1) * pei_pkg::T2_W'(r1_t1);
            r2_ksel <= r1_ksel;
            r2_diff <= r1_diff;
            r2_side <= r1_side;

            r3_p1   <= r2_p1;
            r3_p2   <= r2_p2;
            r3_p3   <= pei_pkg::P3_W'(r2_p2) * pei_pkg::P3_W'(r2_p1);
            r3_t1   <= r2_t1;
            r3_t2   <= r2_t2;
            r3_t3   <= pei_pkg::T3_W'(r2_t2) * pei_pkg::T3_W'(r2_t1);
            r3_ksel <= r2_ksel;
            r3_diff <= r2_diff;
            r3_side <= r2_side;

            r4_p1   <= r3_p1;
            r4_p2   <= r3_p2;
            r4_p3   <= r3_p3;
            r4_p4   <= pei_pkg::P4_W'(r3_p3) * pei_pkg::P4_W'(r3_p1);
            r4_t1   <= r3_t1;
            r4_t2   <= r3_t2;
            r4_t3   <= r3_t3;
            r4_t4   <= pei_pkg::POW_W'(r3_t3) * pei_pkg::POW_W'(r3_t1);
            r4_ksel <= r3_ksel;
            r4_diff <= r3_diff;
            r4_side <= r3_side;

            r5_pmag <= n5_pabs[pei_pkg::POW_W-1:0];
            r5_den  <= n5_tk;
            r5_dmag <= $unsigned(n5_dabs);
            r5_side <= n5_side;

            r6_num  <= pei_pkg::NUM_W'(r5_dmag) * pei_pkg::NUM_W'(r5_pmag);
            r6_den  <= r5_den;
            r6_side <= r5_side;
        end
    end

    assign o_valid = r_v[5];
    assign o_num   = r6_num;
    assign o_den   = r6_den;
    assign o_side  = r6_side;

endmodule

`default_nettype wire

// ----- rtl/core/pei_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
// Depends on pei_pkg. NUM_W stages, all advancing on i_en.
`timescale 1ns / 1ps
`default_nettype none

module pei_divider (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [pei_pkg::NUM_W-1:0]     i_num,
    input  wire [pei_pkg::POW_W-1:0]     i_den,
    input  pei_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [pei_pkg::NUM_W-1:0]    o_quot,
    output pei_pkg::t_side               o_side
);

    localparam int NW = pei_pkg::NUM_W;
    localparam int PW = pei_pkg::POW_W;

    logic [NW-1:0]  r_v;
    logic [PW-1:0]  r_rem  [NW];
    logic [NW-1:0]  r_num  [NW];
    logic [NW-1:0]  r_q    [NW];
    logic [PW-1:0]  r_den  [NW];
    pei_pkg::t_side r_side [NW];

    logic [PW-1:0]  n_rem  [NW];
    logic [NW-1:0]  n_num  [NW];
    logic [NW-1:0]  n_q    [NW];

    logic [PW-1:0]  s_rem  [NW];
    logic [NW-1:0]  s_num  [NW];
    logic [NW-1:0]  s_q    [NW];
    logic [PW-1:0]  s_den  [NW];
    logic [PW:0]    s_trial[NW];
    logic [PW:0]    s_diff [NW];

    // each stage after the first works on the previous stage's registers only; stage 0 takes the inputs
    always_comb begin
        for (int s = 0; s < NW; s++) begin
            if (s == 0) begin
                s_rem[s] = '0;
                s_num[s] = i_num;
                s_q[s]   = '0;
                s_den[s] = i_den;
            end else begin
                s_rem[s] = r_rem[s-1];
                s_num[s] = r_num[s-1];
                s_q[s]   = r_q[s-1];
                s_den[s] = r_den[s-1];
            end
            s_trial[s] = {s_rem[s], s_num[s][NW-1]};
            s_diff[s]  = s_trial[s] - {1'b0, s_den[s]};
            n_rem[s]   = s_diff[s][PW] ? s_trial[s][PW-1:0] : s_diff[s][PW-1:0];
            n_num[s]   = {s_num[s][NW-2:0], 1'b0};
            n_q[s]     = {s_q[s][NW-2:0], ~s_diff[s][PW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NW; s++) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
                r_q[s]   <= n_q[s];
                r_den[s] <= s_den[s];
                r_side[s] <= (s == 0) ? i_side : r_side[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_q[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

`default_nettype wire

// ----- rtl/core/polynomial_easing_interpolator.sv -----
// Pipeline: 6 power stages, 49 divider stages and 1 output register, in that order.
// Throughput: one item per cycle; the whole pipeline holds while the output register
// is full and not taken. Reset clears all valid bits.
// Depends on pei_pkg, pei_power and pei_divider.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_easing_interpolator (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire [pei_pkg::FUNC_W-1:0]            i_func,
    input  wire signed [pei_pkg::VALUE_BITS-1:0] i_start_value,
    input  wire signed [pei_pkg::VALUE_BITS-1:0] i_end_value,
    input  wire [pei_pkg::STEP_W-1:0]            i_step_now,
    input  wire [pei_pkg::STEP_W-1:0]            i_step_total,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic signed [pei_pkg::OUT_W-1:0]     o_eased_value
);

    localparam int SW = pei_pkg::SUM_W;
    localparam int OW = pei_pkg::OUT_W;

    logic                      en;
    logic                      pw_valid, dv_valid;
    logic [pei_pkg::NUM_W-1:0] pw_num, dv_quot;
    logic [pei_pkg::POW_W-1:0] pw_den;
    pei_pkg::t_side            pw_side, dv_side;

    logic                      r_out_v;
    logic signed [OW-1:0]      r_out, n_out;
    logic signed [SW-1:0]      sq, offs, res;

    // advance everything unless a finished result is still waiting
    assign en      = !r_out_v || i_ready;
    assign o_ready = en;

    pei_power u_power (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_func        (i_func),
        .i_start_value (i_start_value),
        .i_end_value   (i_end_value),
        .i_step_now    (i_step_now),
        .i_step_total  (i_step_total),
        .o_valid       (pw_valid),
        .o_num         (pw_num),
        .o_den         (pw_den),
        .o_side        (pw_side)
    );

    pei_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pw_valid),
        .i_num   (pw_num),
        .i_den   (pw_den),
        .i_side  (pw_side),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    always_comb begin
        sq   = dv_side.neg ? -$signed({2'b00, dv_quot}) : $signed({2'b00, dv_quot});
        offs = {{(SW-pei_pkg::VALUE_BITS){dv_side.offset[pei_pkg::VALUE_BITS-1]}},
                dv_side.offset};
        res  = dv_side.sub ? offs - sq : offs + sq;
        case (dv_side.kind)
            pei_pkg::KIND_POLY: begin
                if (res[SW-1:OW-1] == '0 || res[SW-1:OW-1] == '1) begin
                    n_out = res[OW-1:0];
                end else begin
                    n_out = res[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
                end
            end
            pei_pkg::KIND_END: begin
                n_out = offs[OW-1:0];
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_v;
    assign o_eased_value = r_out;

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |-> !o_ready)
        else $error("input taken while output register full");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_valid)
        else $error("output valid right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_eased_value)))
        else $error("waiting result changed");

endmodule

`default_nettype wire
